// ----- sv/simb_pkg.sv -----
// ----------------------------------------------------------------------------
// simb_pkg
// Shared widths, defaults, register indexes and sequencer states for the
// sector interleave map builder.
// ----------------------------------------------------------------------------
package simb_pkg;

  // Payload widths
  localparam int TRACK_W    = 7;
  localparam int SLOT_W     = 6;
  localparam int VAL_W      = 7;   // position plus skew before reduction
  localparam int SKEW_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Defaults for the top level parameters
  localparam int DEF_NUM_TRACKS  = 77;
  localparam int DEF_MAX_SECTORS = 52;

  // Track geometry
  localparam int SD_SECTORS    = 26;
  localparam int DD_SECTORS    = 52;
  localparam int SD_TRACK_SKEW = 4;
  localparam int DD_TRACK_SKEW = 7;
  localparam int RELOAD_TRACKS = 3;   // tracks that reload the skew

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOUBLE_DENSITY = 2'd0,
    REG_USE_SKEW       = 2'd1,
    REG_TRACK_SKEWS    = 2'd2,
    REG_INTER_TRACK    = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_REDUCE,
    ST_PROBE,
    ST_EMIT,
    ST_ADVANCE
  } state_t;

endpackage

// ----- sv/simb_in_if.sv -----
// ----------------------------------------------------------------------------
// simb_in_if
// Input channel: one track number per beat.
// ----------------------------------------------------------------------------
interface simb_in_if;
  logic                         valid;
  logic                         ready;
  logic [simb_pkg::TRACK_W-1:0] track;

  modport source (output valid, output track, input ready);
  modport sink   (input valid, input track, output ready);
endinterface

// ----- sv/simb_out_if.sv -----
// ----------------------------------------------------------------------------
// simb_out_if
// Result channel: one (slot, sector number, last) per beat.
// ----------------------------------------------------------------------------
interface simb_out_if;
  logic                        valid;
  logic                        ready;
  logic [simb_pkg::SLOT_W-1:0] slot;
  logic [simb_pkg::SLOT_W-1:0] sector_number;
  logic                        last;

  modport source (output valid, output slot, output sector_number, output last,
                  input ready);
  modport sink   (input valid, input slot, input sector_number, input last,
                  output ready);
endinterface

// ----- sv/simb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// simb_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface simb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [simb_pkg::CFG_IDX_W-1:0]  index;
  logic [simb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/simb_step_unit.sv -----
// ----------------------------------------------------------------------------
// simb_step_unit
// Shared add / conditional-subtract unit: res = a + b, minus n once when the
// sum reaches n. Every position update of the sequencer goes through here.
// ----------------------------------------------------------------------------
module simb_step_unit (
  input  logic [simb_pkg::VAL_W-1:0]  a,
  input  logic [simb_pkg::SKEW_W-1:0] b,
  input  logic [simb_pkg::SLOT_W-1:0] n,
  output logic [simb_pkg::VAL_W-1:0]  res,
  output logic                        ge
);

  logic [simb_pkg::VAL_W-1:0] sum;
  logic [simb_pkg::VAL_W-1:0] n_ext;

  assign sum   = a + simb_pkg::VAL_W'(b);
  assign n_ext = simb_pkg::VAL_W'(n);
  assign ge    = (sum >= n_ext);
  assign res   = ge ? (sum - n_ext) : sum;

endmodule

// ----- sv/sector_interleave_map_builder.sv -----
// ----------------------------------------------------------------------------
// sector_interleave_map_builder
// Builds one track's logical-sector to physical-slot map per input beat,
// with optional skew interleave and linear probing past taken slots.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | track
//  out_ch  | out | valid/ready  | slot, sector_number, last
//  cfg_ch  | in  | valid/ready  | index, data (always ready)
//
//  One track yields N beats (26 or 52); out-of-range tracks yield none.
//  Identity mode: one beat per cycle while out_ch.ready is held high.
//  Skew mode: per sector STEP, REDUCE (repeated per reduction past the
//  first), PROBE (repeated per occupied slot) and EMIT, all through the one
//  step unit; ADVANCE closes the track. in_ch.ready is high only when idle.
//  Reset (rst_n low, synchronous) clears all but the payload registers.
//  A stalled out_ch holds the beat in the output registers.
// ----------------------------------------------------------------------------
module sector_interleave_map_builder #(
  parameter int NUM_TRACKS  = simb_pkg::DEF_NUM_TRACKS,
  parameter int MAX_SECTORS = simb_pkg::DEF_MAX_SECTORS
) (
  input  logic        clk,
  input  logic        rst_n,
  simb_in_if.sink     in_ch,
  simb_out_if.source  out_ch,
  simb_cfg_if.sink    cfg_ch
);

  localparam int SD_N      = (simb_pkg::SD_SECTORS > MAX_SECTORS) ?
                             MAX_SECTORS : simb_pkg::SD_SECTORS;
  localparam int DD_N      = (simb_pkg::DD_SECTORS > MAX_SECTORS) ?
                             MAX_SECTORS : simb_pkg::DD_SECTORS;
  localparam int OCC_IDX_W = $clog2(MAX_SECTORS);

  // Configuration registers
  logic                            dd_r;
  logic                            use_skew_r;
  logic [simb_pkg::CFG_DATA_W-1:0] track_skews_r;
  logic                            inter_r;

  // Sequencer and datapath
  simb_pkg::state_t              state_r, state_nxt;
  logic                          skew_mode_r, skew_mode_nxt;
  logic [simb_pkg::SLOT_W-1:0]   n_r, n_nxt;
  logic [simb_pkg::SLOT_W-1:0]   pos_r, pos_nxt;
  logic [simb_pkg::SKEW_W-1:0]   skew_r, skew_nxt;
  logic [simb_pkg::VAL_W-1:0]    val_r, val_nxt;
  logic [simb_pkg::SLOT_W-1:0]   sec_r, sec_nxt;
  logic [MAX_SECTORS-1:0]        occ_r, occ_nxt;

  // Output registers
  logic [simb_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [simb_pkg::SLOT_W-1:0]   out_sec_r, out_sec_nxt;
  logic                          out_last_r, out_last_nxt;

  // Step unit operands
  logic [simb_pkg::VAL_W-1:0]    su_a;
  logic [simb_pkg::SKEW_W-1:0]   su_b;
  logic [simb_pkg::VAL_W-1:0]    su_res;
  logic                          su_ge;

  logic                          in_beat, out_beat;
  logic                          track_ok, reload;
  logic [simb_pkg::SLOT_W-1:0]   n_cfg;
  logic [simb_pkg::SKEW_W-1:0]   reload_skew;
  logic [simb_pkg::SKEW_W-1:0]   track_gap;
  logic [OCC_IDX_W-1:0]          occ_idx;
  logic                          occ_hit;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  assign track_ok = ({1'b0, in_ch.track} < (simb_pkg::TRACK_W + 1)'(NUM_TRACKS));
  assign reload   = (in_ch.track < simb_pkg::TRACK_W'(simb_pkg::RELOAD_TRACKS));
  assign n_cfg    = dd_r ? simb_pkg::SLOT_W'(DD_N) : simb_pkg::SLOT_W'(SD_N);
  assign track_gap = dd_r ? simb_pkg::SKEW_W'(simb_pkg::DD_TRACK_SKEW)
                          : simb_pkg::SKEW_W'(simb_pkg::SD_TRACK_SKEW);
  assign occ_idx  = val_r[OCC_IDX_W-1:0];
  assign occ_hit  = occ_r[occ_idx];

  // Skew nibble for the reload tracks
  always_comb begin
    case (in_ch.track[1:0])
      2'd0:    reload_skew = track_skews_r[3:0];
      2'd1:    reload_skew = track_skews_r[7:4];
      default: reload_skew = track_skews_r[11:8];
    endcase
  end

  // Ports
  assign in_ch.ready          = (state_r == simb_pkg::ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = (state_r == simb_pkg::ST_EMIT);
  assign out_ch.slot          = out_slot_r;
  assign out_ch.sector_number = out_sec_r;
  assign out_ch.last          = out_last_r;

  // Shared unit
  simb_step_unit u_step (
    .a   (su_a),
    .b   (su_b),
    .n   (n_r),
    .res (su_res),
    .ge  (su_ge)
  );

  // Operand select
  always_comb begin
    su_a = val_r;
    su_b = '0;
    case (state_r)
      simb_pkg::ST_STEP: begin
        su_a = simb_pkg::VAL_W'(pos_r);
        su_b = skew_r;
      end
      simb_pkg::ST_PROBE: begin
        su_b = simb_pkg::SKEW_W'(1);
      end
      simb_pkg::ST_ADVANCE: begin
        su_a = simb_pkg::VAL_W'(pos_r);
        su_b = track_gap;
      end
      default: begin
        su_b = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      simb_pkg::ST_IDLE: begin
        if (in_beat && track_ok) begin
          state_nxt = use_skew_r ? simb_pkg::ST_STEP : simb_pkg::ST_EMIT;
        end
      end
      simb_pkg::ST_STEP:   state_nxt = simb_pkg::ST_REDUCE;
      simb_pkg::ST_REDUCE: begin
        if (!su_ge) begin
          state_nxt = simb_pkg::ST_PROBE;
        end
      end
      simb_pkg::ST_PROBE: begin
        if (!occ_hit) begin
          state_nxt = simb_pkg::ST_EMIT;
        end
      end
      simb_pkg::ST_EMIT: begin
        if (out_beat) begin
          if (out_last_r) begin
            state_nxt = skew_mode_r ? simb_pkg::ST_ADVANCE : simb_pkg::ST_IDLE;
          end else if (skew_mode_r) begin
            state_nxt = simb_pkg::ST_STEP;
          end
        end
      end
      simb_pkg::ST_ADVANCE: state_nxt = simb_pkg::ST_IDLE;
      default:              state_nxt = simb_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    skew_mode_nxt = skew_mode_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    skew_nxt      = skew_r;
    val_nxt       = val_r;
    sec_nxt       = sec_r;
    occ_nxt       = occ_r;
    out_slot_nxt  = out_slot_r;
    out_sec_nxt   = out_sec_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      simb_pkg::ST_IDLE: begin
        if (in_beat && track_ok) begin
          skew_mode_nxt = use_skew_r;
          n_nxt         = n_cfg;
          sec_nxt       = simb_pkg::SLOT_W'(1);
          // identity mode: first beat ready at once
          out_slot_nxt  = '0;
          out_sec_nxt   = simb_pkg::SLOT_W'(1);
          out_last_nxt  = (n_cfg == simb_pkg::SLOT_W'(1));
          if (use_skew_r) begin
            occ_nxt = '0;
            if (reload) begin
              skew_nxt = reload_skew;
              pos_nxt  = '0;
            end
          end
        end
      end
      simb_pkg::ST_STEP: begin
        val_nxt = su_res;
      end
      simb_pkg::ST_REDUCE: begin
        if (su_ge) begin
          val_nxt = su_res;
        end
      end
      simb_pkg::ST_PROBE: begin
        if (occ_hit) begin
          val_nxt = su_res;
        end else begin
          occ_nxt[occ_idx] = 1'b1;
          pos_nxt          = val_r[simb_pkg::SLOT_W-1:0];
          out_slot_nxt     = val_r[simb_pkg::SLOT_W-1:0];
          out_sec_nxt      = sec_r;
          out_last_nxt     = (sec_r == n_r);
        end
      end
      simb_pkg::ST_EMIT: begin
        if (out_beat && !out_last_r) begin
          sec_nxt = sec_r + simb_pkg::SLOT_W'(1);
          if (!skew_mode_r) begin
            out_slot_nxt = sec_r;
            out_sec_nxt  = sec_r + simb_pkg::SLOT_W'(1);
            out_last_nxt = ((sec_r + simb_pkg::SLOT_W'(1)) == n_r);
          end
        end
      end
      simb_pkg::ST_ADVANCE: begin
        pos_nxt = inter_r ? su_res[simb_pkg::SLOT_W-1:0] : '0;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_r          <= 1'b0;
      use_skew_r    <= 1'b0;
      track_skews_r <= '0;
      inter_r       <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (simb_pkg::cfg_idx_t'(cfg_ch.index))
        simb_pkg::REG_DOUBLE_DENSITY: dd_r          <= cfg_ch.data[0];
        simb_pkg::REG_USE_SKEW:       use_skew_r    <= cfg_ch.data[0];
        simb_pkg::REG_TRACK_SKEWS:    track_skews_r <= cfg_ch.data;
        simb_pkg::REG_INTER_TRACK:    inter_r       <= cfg_ch.data[0];
        default:                      inter_r       <= inter_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= simb_pkg::ST_IDLE;
      skew_mode_r <= 1'b0;
      pos_r       <= '0;
      skew_r      <= '0;
      occ_r       <= '0;
      sec_r       <= '0;
      n_r         <= simb_pkg::SLOT_W'(SD_N);
    end else begin
      state_r     <= state_nxt;
      skew_mode_r <= skew_mode_nxt;
      pos_r       <= pos_nxt;
      skew_r      <= skew_nxt;
      occ_r       <= occ_nxt;
      sec_r       <= sec_nxt;
      n_r         <= n_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_slot_r <= out_slot_nxt;
    out_sec_r  <= out_sec_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_slot_r < n_r))
    else $error("slot beyond sector count");

  a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && skew_mode_r) |-> occ_r[out_slot_r[OCC_IDX_W-1:0]])
    else $error("emitted slot not marked occupied");

  a_sector_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && !out_last_r) |=> (sec_r == $past(sec_r) + simb_pkg::SLOT_W'(1)))
    else $error("sector count did not advance");

  a_identity_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_last_r && !skew_mode_r) |=> (state_r == simb_pkg::ST_IDLE))
    else $error("identity track did not finish");

endmodule

// ----- bench/sector_interleave_map_builder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_interleave_map_builder_test
// Self-checking bench: drives track numbers and register writes, predicts the
// slot/sector beats of every track with an in-bench map builder and compares
// each result beat field by field under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module sector_interleave_map_builder_test;

  localparam int NUM_TRACKS   = simb_pkg::DEF_NUM_TRACKS;
  localparam int MAX_SECTORS  = simb_pkg::DEF_MAX_SECTORS;
  localparam int RANDOM_ITEMS = 300;
  localparam int RANDOM_SETS  = 8;
  localparam int QUIET_CYCLES = 16;

  typedef struct packed {
    logic [simb_pkg::SLOT_W-1:0] slot;
    logic [simb_pkg::SLOT_W-1:0] sector_number;
    logic                        last;
  } sector_beat_t;

  logic clk;
  logic rst_n;

  simb_in_if  in_ch ();
  simb_out_if out_ch ();
  simb_cfg_if cfg_ch ();

  sector_interleave_map_builder #(
    .NUM_TRACKS  (NUM_TRACKS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Pending tracks and expected beats
  logic [simb_pkg::TRACK_W-1:0] track_queue[$];
  sector_beat_t                 sector_map_q[$];

  // Register copies
  logic        dd_mode;
  logic        skew_on;
  logic [11:0] skew_nibbles;
  logic        step_between;

  // Map builder state
  int unsigned                 map_pos;
  logic [simb_pkg::SKEW_W-1:0] map_skew;
  logic [63:0]                 taken_slots;

  // Stall control and bookkeeping
  int   send_idle_pct;
  int   recv_stall_pct;
  logic in_taken;
  int   tracks_queued;
  int   tracks_taken;
  int   skewed_tracks;
  int   beats_checked;
  int   reg_writes;
  int   fail_count;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int track_sectors();
    int n;
    n = dd_mode ? simb_pkg::DD_SECTORS : simb_pkg::SD_SECTORS;
    if (n > MAX_SECTORS) n = MAX_SECTORS;
    return n;
  endfunction

  // Work out every beat of one track and advance the map state
  function automatic void build_track_map(input logic [simb_pkg::TRACK_W-1:0] trk);
    int           n;
    sector_beat_t beat;
    n = track_sectors();
    if (trk >= NUM_TRACKS) return;
    if (!skew_on) begin
      for (int s = 1; s <= n; s++) begin
        beat.slot          = simb_pkg::SLOT_W'(s - 1);
        beat.sector_number = simb_pkg::SLOT_W'(s);
        beat.last          = (s == n);
        sector_map_q.push_back(beat);
      end
      return;
    end
    skewed_tracks++;
    if (trk < simb_pkg::RELOAD_TRACKS) begin
      map_skew = skew_nibbles[4 * int'(trk) +: 4];
      map_pos  = 0;
    end
    taken_slots = '0;
    for (int s = 1; s <= n; s++) begin
      map_pos = (map_pos + map_skew) % n;
      // probe forward past slots already used on this track
      while (taken_slots[map_pos]) map_pos = (map_pos + 1) % n;
      taken_slots[map_pos] = 1'b1;
      beat.slot          = simb_pkg::SLOT_W'(map_pos);
      beat.sector_number = simb_pkg::SLOT_W'(s);
      beat.last          = (s == n);
      sector_map_q.push_back(beat);
    end
    if (step_between)
      map_pos = (map_pos + (dd_mode ? simb_pkg::DD_TRACK_SKEW
                                    : simb_pkg::SD_TRACK_SKEW)) % n;
    else map_pos = 0;
  endfunction

  function automatic void report_field(input string field, input int want, input int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endfunction

  // Input driver: one track beat per handshake, random sender gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (track_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.track <= track_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
          in_ch.track <= simb_pkg::TRACK_W'($urandom_range((1 << simb_pkg::TRACK_W) - 1));
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on accepted tracks, check accepted result beats
  always @(posedge clk) begin
    sector_beat_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        tracks_taken++;
        build_track_map(in_ch.track);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sector_map_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none actual slot %0d sector %0d last %0d",
                   $time, out_ch.slot, out_ch.sector_number, out_ch.last);
        end else begin
          want = sector_map_q.pop_front();
          beats_checked++;
          if (out_ch.slot !== want.slot)
            report_field("slot", int'(want.slot), int'(out_ch.slot));
          if (out_ch.sector_number !== want.sector_number)
            report_field("sector_number", int'(want.sector_number),
                         int'(out_ch.sector_number));
          if (out_ch.last !== want.last)
            report_field("last", int'(want.last), int'(out_ch.last));
        end
      end
    end
  end

  // One register write beat; the copy is updated once the beat is taken
  task automatic write_reg(input simb_pkg::cfg_idx_t idx,
                           input logic [simb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      simb_pkg::REG_DOUBLE_DENSITY: dd_mode      = data[0];
      simb_pkg::REG_USE_SKEW:       skew_on      = data[0];
      simb_pkg::REG_TRACK_SKEWS:    skew_nibbles = data[11:0];
      simb_pkg::REG_INTER_TRACK:    step_between = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every track is taken and every beat has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (track_queue.size() != 0 || in_ch.valid || sector_map_q.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic queue_track(input logic [simb_pkg::TRACK_W-1:0] trk);
    track_queue.push_back(trk);
    tracks_queued++;
  endtask

  // Stall pattern follows how far the stimulus has got
  task automatic pick_stalls();
    int total;
    total = RANDOM_ITEMS + 21;
    if (tracks_queued < total / 3) begin
      send_idle_pct  = 23;
      recv_stall_pct = 70;
    end else if (tracks_queued < 2 * total / 3) begin
      send_idle_pct  = 70;
      recv_stall_pct = 23;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endtask

  // 1-bit register data with random upper bits
  function automatic logic [simb_pkg::CFG_DATA_W-1:0] flag_data(input logic bit0);
    logic [simb_pkg::CFG_DATA_W-1:0] d;
    d    = simb_pkg::CFG_DATA_W'($urandom_range((1 << simb_pkg::CFG_DATA_W) - 1));
    d[0] = bit0;
    return d;
  endfunction

  // Stimulus
  initial begin
    int                              per_set;
    int                              cur;
    int                              r;
    logic [simb_pkg::CFG_DATA_W-1:0] skews;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.track   = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = simb_pkg::REG_DOUBLE_DENSITY;
    cfg_ch.data   = '0;
    dd_mode       = 1'b0;
    skew_on       = 1'b0;
    skew_nibbles  = '0;
    step_between  = 1'b0;
    map_pos       = 0;
    map_skew      = '0;
    taken_slots   = '0;
    send_idle_pct  = 23;
    recv_stall_pct = 70;
    tracks_queued = 0;
    tracks_taken  = 0;
    skewed_tracks = 0;
    beats_checked = 0;
    reg_writes    = 0;
    fail_count    = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: identity single density, edge and out-of-range tracks
    pick_stalls();
    queue_track(0);
    queue_track(76);
    queue_track(77);
    queue_track(127);
    wait_drained();

    // Identity double density; upper data bits must be ignored
    write_reg(simb_pkg::REG_DOUBLE_DENSITY, 12'hFFF);
    write_reg(simb_pkg::REG_USE_SKEW, 12'hFFE);
    pick_stalls();
    queue_track(0);
    queue_track(63);
    wait_drained();

    // Skew on: zero skew on track 0, max on track 1, one on track 2
    write_reg(simb_pkg::REG_DOUBLE_DENSITY, 12'h000);
    write_reg(simb_pkg::REG_USE_SKEW, 12'h001);
    write_reg(simb_pkg::REG_TRACK_SKEWS, 12'h1F0);
    write_reg(simb_pkg::REG_INTER_TRACK, 12'h001);
    pick_stalls();
    queue_track(0);
    queue_track(1);
    queue_track(2);
    queue_track(3);
    queue_track(4);
    queue_track(100);
    queue_track(5);
    wait_drained();

    // Double density, all skews max, reload tracks out of order
    write_reg(simb_pkg::REG_DOUBLE_DENSITY, 12'h001);
    write_reg(simb_pkg::REG_TRACK_SKEWS, 12'hFFF);
    pick_stalls();
    queue_track(2);
    queue_track(1);
    queue_track(0);
    queue_track(40);
    queue_track(76);
    wait_drained();

    // Back to single density with a stored double-density position
    write_reg(simb_pkg::REG_DOUBLE_DENSITY, 12'hFFE);
    write_reg(simb_pkg::REG_INTER_TRACK, 12'h000);
    pick_stalls();
    queue_track(10);
    queue_track(0);
    queue_track(11);
    wait_drained();

    // Random sets: mostly ascending tracks from zero, some noise
    per_set = RANDOM_ITEMS / RANDOM_SETS;
    for (int set_i = 0; set_i < RANDOM_SETS; set_i++) begin
      if ($urandom_range(3) != 0)
        write_reg(simb_pkg::REG_DOUBLE_DENSITY, flag_data(1'($urandom_range(1))));
      if ($urandom_range(3) != 0)
        write_reg(simb_pkg::REG_USE_SKEW, flag_data($urandom_range(3) != 0));
      if ($urandom_range(3) != 0) begin
        r = $urandom_range(3);
        if (r == 0) skews = 12'h000;
        else if (r == 1) skews = 12'hFFF;
        else skews = simb_pkg::CFG_DATA_W'($urandom_range(4095));
        write_reg(simb_pkg::REG_TRACK_SKEWS, skews);
      end
      if ($urandom_range(3) != 0)
        write_reg(simb_pkg::REG_INTER_TRACK, flag_data(1'($urandom_range(1))));
      pick_stalls();
      cur = 0;
      for (int i = 0; i < per_set + 1; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          queue_track(simb_pkg::TRACK_W'(
            $urandom_range((1 << simb_pkg::TRACK_W) - 1, NUM_TRACKS)));
        end else if (r < 14) begin
          queue_track(simb_pkg::TRACK_W'($urandom_range(NUM_TRACKS - 1)));
        end else begin
          queue_track(simb_pkg::TRACK_W'(cur));
          cur += ($urandom_range(3) == 0) ? $urandom_range(12, 2) : 1;
          if (cur >= NUM_TRACKS || $urandom_range(24) == 0) cur = 0;
        end
      end
      wait_drained();
    end

    $display("Checked %0d result beats from %0d accepted tracks (%0d skewed),",
             beats_checked, tracks_taken, skewed_tracks);
    $display("%0d register writes; sender/receiver stalls 23/70, then 70/23, then none.",
             reg_writes);
    if (fail_count == 0 && sector_map_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d beats still expected", $time, sector_map_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
sv/simb_pkg.sv
sv/simb_in_if.sv
sv/simb_out_if.sv
sv/simb_cfg_if.sv
sv/simb_step_unit.sv
sv/sector_interleave_map_builder.sv
bench/sector_interleave_map_builder_test.sv
